>>> design/moving_average_filter_defines.svh
// ----------------------------------------------------------------------------
// Moving average filter assertion macros
// Shared concurrent assertion forms for the filter blocks.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

// same-cycle implication
`define MVAVG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MVAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mvavg_pkg.sv
// ----------------------------------------------------------------------------
// Moving average filter package
// Function codes and the stage control group shared by the filter blocks.
// ----------------------------------------------------------------------------
package mvavg_pkg;

	typedef enum logic [0:0] {
		FUNC_PUSH    = 1'b0,
		FUNC_PRELOAD = 1'b1
	} func_t;

	typedef struct packed {
		logic valid;
		logic preload;
	} s1_ctrl_t;

endpackage

>>> design/mvavg_in_if.sv
// ----------------------------------------------------------------------------
// Moving average filter sample channel
// Valid/ready channel carrying a function code and one converter sample.
// ----------------------------------------------------------------------------
interface mvavg_in_if
	import mvavg_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	func_t                  func;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output func, output sample, input ready);
	modport sink (input valid, input func, input sample, output ready);
endinterface

>>> design/mvavg_out_if.sv
// ----------------------------------------------------------------------------
// Moving average filter result channel
// Valid/ready channel carrying one truncated average.
// ----------------------------------------------------------------------------
interface mvavg_out_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

>>> design/moving_average_filter.sv
// ----------------------------------------------------------------------------
// Moving average filter
// Boxcar mean over the last 2^DEPTH_LOG2 samples, one result per item.
//
//   channel  role    payload
//   feed     sink    func, sample
//   result   source  average
//
// Throughput is one item per cycle while the result is not stalled; the feed
// transfer reaches the result valid through the ring memory read into the
// stage register, then the running sum update into the output register.
// Reset clears the sum, position and fill value at once; no clearing pass.
// A stalled result holds the stage behind it; feed ready drops only when
// that stage is full and cannot advance.
// ----------------------------------------------------------------------------
`include "moving_average_filter_defines.svh"

module moving_average_filter
	import mvavg_pkg::*;
#(
	parameter int DEPTH_LOG2  = 6,
	parameter int SAMPLE_BITS = 12
) (
	input logic         clk,
	input logic         arst_n,
	mvavg_in_if.sink    feed,
	mvavg_out_if.source result
);
	s1_ctrl_t               ctrl_s1;
	logic [SAMPLE_BITS-1:0] old_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   advance;
	logic                   in_fire;

	assign feed.ready = !ctrl_s1.valid || advance;
	assign in_fire    = feed.valid && feed.ready;

	mvavg_ring #(
		.DEPTH_LOG2  (DEPTH_LOG2),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_func   (feed.func),
		.in_sample (feed.sample),
		.advance   (advance),
		.ctrl_s1   (ctrl_s1),
		.old_s1    (old_s1),
		.sample_s1 (sample_s1)
	);

	mvavg_accum #(
		.DEPTH_LOG2  (DEPTH_LOG2),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.old_s1    (old_s1),
		.sample_s1 (sample_s1),
		.advance   (advance),
		.result    (result)
	);

	`MVAVG_ASSERT_NOW(a_stall_blocks_feed, clk, arst_n, ctrl_s1.valid && !advance, !feed.ready, "feed ready while stage stalled")
	`MVAVG_ASSERT_NEXT(a_preload_enters, clk, arst_n, in_fire && feed.func == FUNC_PRELOAD, ctrl_s1.valid && ctrl_s1.preload, "preload transfer lost")
	`MVAVG_ASSERT_NEXT(a_advance_shows, clk, arst_n, advance, result.valid, "result missing after advance")

endmodule

>>> design/mvavg_ring.sv
// ----------------------------------------------------------------------------
// Moving average sample ring
// Sample memory with write position and preload fill value; reads the oldest
// entry on each transfer and writes a pushed sample back as the stage advances.
// ----------------------------------------------------------------------------
module mvavg_ring
	import mvavg_pkg::*;
#(
	parameter int DEPTH_LOG2  = 6,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_fire,
	input  func_t                  in_func,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   advance,
	output s1_ctrl_t               ctrl_s1,
	output logic [SAMPLE_BITS-1:0] old_s1,
	output logic [SAMPLE_BITS-1:0] sample_s1
);
	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
	logic [DEPTH_LOG2-1:0]  pos_q;
	logic                   wrapped_q;
	logic [SAMPLE_BITS-1:0] fill_q;

	logic [SAMPLE_BITS-1:0] rd_s1;
	logic [SAMPLE_BITS-1:0] fill_s1;
	logic [DEPTH_LOG2-1:0]  pos_s1;
	logic                   use_fill_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1 <= ring_mem[pos_q];
		end
		if (advance && !ctrl_s1.preload) begin
			ring_mem[pos_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1   <= in_sample;
			pos_s1      <= pos_q;
			fill_s1     <= fill_q;
			use_fill_s1 <= !wrapped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			fill_q    <= '0;
			ctrl_s1   <= '0;
		end else begin
			if (in_fire) begin
				ctrl_s1.valid   <= 1'b1;
				ctrl_s1.preload <= (in_func == FUNC_PRELOAD);
				if (in_func == FUNC_PRELOAD) begin
					pos_q     <= '0;
					wrapped_q <= 1'b0;
					fill_q    <= in_sample;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == DEPTH_LOG2'(DEPTH - 1)) begin
						wrapped_q <= 1'b1;
					end
				end
			end else if (advance) begin
				ctrl_s1.valid <= 1'b0;
			end
		end
	end

	// entries not rewritten since the last preload hold the fill value
	assign old_s1 = use_fill_s1 ? fill_s1 : rd_s1;

endmodule

>>> design/mvavg_accum.sv
// ----------------------------------------------------------------------------
// Moving average accumulator
// Running sum update and the result output register.
// ----------------------------------------------------------------------------
module mvavg_accum
	import mvavg_pkg::*;
#(
	parameter int DEPTH_LOG2  = 6,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  s1_ctrl_t               ctrl_s1,
	input  logic [SAMPLE_BITS-1:0] old_s1,
	input  logic [SAMPLE_BITS-1:0] sample_s1,
	output logic                   advance,
	mvavg_out_if.source            result
);
	localparam int SUM_BITS = SAMPLE_BITS + DEPTH_LOG2;

	logic [SUM_BITS-1:0]    sum_q;
	logic [SUM_BITS-1:0]    sum_next;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic                   out_valid_q;

	assign advance = ctrl_s1.valid && (!out_valid_q || result.ready);

	always_comb begin
		if (ctrl_s1.preload) begin
			sum_next = {sample_s1, {DEPTH_LOG2{1'b0}}};
		end else begin
			sum_next = sum_q - SUM_BITS'(old_s1) + SUM_BITS'(sample_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			avg_q <= sum_next[SUM_BITS-1:DEPTH_LOG2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				sum_q       <= sum_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid   = out_valid_q;
	assign result.average = avg_q;

endmodule
